/* rtl/pfms_pkg.sv */
package pfms_pkg;

   localparam int PROD_W = 66;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_STEP  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ACT_BRAKE = 3'd0,
      ACT_SLOW  = 3'd1,
      ACT_KEEP  = 3'd2,
      ACT_GAIN  = 3'd3,
      ACT_FAST  = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      CSR_TIME_STEP   = 3'd0,
      CSR_PATH_POINTS = 3'd1,
      CSR_ACCEL_BRAKE = 3'd2,
      CSR_ACCEL_SLOW  = 3'd3,
      CSR_ACCEL_KEEP  = 3'd4,
      CSR_ACCEL_GAIN  = 3'd5,
      CSR_ACCEL_FAST  = 3'd6
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_STOP,
      ST_DTQ,
      ST_T2,
      ST_P1,
      ST_P2,
      ST_SPD,
      ST_SRCH,
      ST_SCMP,
      ST_CLAMP,
      ST_RR,
      ST_RL,
      ST_WDIV,
      ST_WQ,
      ST_LX,
      ST_LXR,
      ST_LYR,
      ST_LHR
   } state_type;

   typedef struct packed {
      logic signed [31:0] station;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] heading;
   } point_type;

   function automatic logic signed [31:0] sat_s32(input logic signed [PROD_W-1:0] v);
      logic signed [31:0] r;
      if (v[PROD_W-1:31] == '0 || v[PROD_W-1:31] == '1) begin
         r = v[31:0];
      end else if (v[PROD_W-1]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7fff_ffff;
      end
      return r;
   endfunction

   function automatic logic [30:0] sat_u31(input logic signed [PROD_W-1:0] v);
      logic [30:0] r;
      if (v[PROD_W-1]) begin
         r = '0;
      end else if (v[PROD_W-2:31] != '0) begin
         r = '1;
      end else begin
         r = v[30:0];
      end
      return r;
   endfunction

endpackage

/* rtl/path_following_motion_step_unit.sv */
// Channel       Handshake               Payload
// request       start, busy             req_op .. req_action
// response      rsp_valid (one cycle)   rsp_next_station .. rsp_interpolated
// csr           csr_we                  csr_index, csr_wdata
//
// A waypoint write leaves busy low.
// A step uses the serial divider (once for a shortened step, once for the weight),
// a binary search on the single path memory read port, and shared multiplies.
// Synchronous reset clears control and loads CSR defaults; path memory is not cleared.
// The response strobe cannot be stalled; busy falls in the cycle it is shown.
module path_following_motion_step_unit #(
   parameter int PATH_DEPTH = 1024,
   parameter int FRAC_BITS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_op,
   input  logic [9:0]         req_point_index,
   input  logic signed [31:0] req_station,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_heading,
   input  logic [30:0]        req_speed,
   input  logic [2:0]         req_action,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_next_station,
   output logic signed [31:0] rsp_next_x,
   output logic signed [31:0] rsp_next_y,
   output logic signed [31:0] rsp_next_heading,
   output logic [30:0]        rsp_next_speed,
   output logic [9:0]         rsp_segment_index,
   output logic               rsp_interpolated,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int AW  = $clog2(PATH_DEPTH);
   localparam int CW  = AW + 1;
   localparam int DW  = 33 + FRAC_BITS;
   localparam int DCW = $clog2(DW);
   localparam int PW  = pfms_pkg::PROD_W;
   localparam int TS_RST    = ((3 << FRAC_BITS) + 5) / 10;
   localparam int BRAKE_RST = -4 * (1 << FRAC_BITS);
   localparam int SLOW_RST  = -2 * (1 << FRAC_BITS);
   localparam int GAIN_RST  = 3 * (1 << FRAC_BITS) / 2;
   localparam int FAST_RST  = 3 * (1 << FRAC_BITS);

   pfms_pkg::point_type mem [PATH_DEPTH];
   pfms_pkg::point_type rd_ff;
   logic [AW-1:0]       rd_addr;
   logic                mem_we;

   logic [30:0]        time_step_ff;
   logic [10:0]        path_points_ff;
   logic signed [31:0] accel_brake_ff, accel_slow_ff, accel_keep_ff;
   logic signed [31:0] accel_gain_ff, accel_fast_ff;

   pfms_pkg::state_type state_ff, state_in, ret_ff, ret_in;
   logic signed [31:0] a_ff, a_in, s_ff, s_in, px_ff, px_in, py_ff, py_in, ph_ff, ph_in;
   logic [30:0]        dt_ff, dt_in, v_ff, v_in, t2_ff, t2_in, spd_ff, spd_in;
   logic signed [PW-1:0] acc_ff, acc_in, prod_ff;
   logic signed [31:0] sn_ff, sn_in, w_ff, w_in, ox_ff, ox_in, oy_ff, oy_in;
   logic [CW-1:0]      lo_ff, lo_in, cnt_ff, cnt_in, mid_ff, mid_in, n_ff, n_in;
   pfms_pkg::point_type right_ff, right_in, left_ff, left_in;
   logic signed [32:0] mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;
   logic [32:0]        div_rem_ff, div_rem_in, div_den_ff, div_den_in;
   logic [DW-1:0]      div_quo_ff, div_quo_in;
   logic [DCW-1:0]     div_cnt_ff, div_cnt_in;
   logic               div_neg_ff, div_neg_in;

   logic               rsp_valid_ff, rsp_valid_in, rsp_interp_ff, rsp_interp_in;
   logic signed [31:0] rsp_st_ff, rsp_st_in, rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic signed [31:0] rsp_h_ff, rsp_h_in;
   logic [30:0]        rsp_spd_ff, rsp_spd_in;
   logic [9:0]         rsp_idx_ff, rsp_idx_in;

   logic signed [31:0] accel_sel;
   logic [CW-1:0]      n_c, mid_c, lo_c, lo_m1;
   logic signed [PW-1:0] prod_sh, v_sh;
   logic [33:0]        div_trial;
   logic signed [32:0] den_c, num_c;
   logic [32:0]        den_abs, num_abs;
   logic [DW:0]        quo_x;

   assign busy              = (state_ff != pfms_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_next_station  = rsp_st_ff;
   assign rsp_next_x        = rsp_x_ff;
   assign rsp_next_y        = rsp_y_ff;
   assign rsp_next_heading  = rsp_h_ff;
   assign rsp_next_speed    = rsp_spd_ff;
   assign rsp_segment_index = rsp_idx_ff;
   assign rsp_interpolated  = rsp_interp_ff;

   assign mem_we = start && !busy && (req_op == pfms_pkg::OP_WRITE)
                   && (32'(req_point_index) < PATH_DEPTH);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[AW'(req_point_index)] <= '{req_station, req_pos_x, req_pos_y, req_heading};
      end
      rd_ff <= mem[rd_addr];
   end

   always_comb begin
      case (req_action)
         pfms_pkg::ACT_BRAKE: accel_sel = accel_brake_ff;
         pfms_pkg::ACT_SLOW:  accel_sel = accel_slow_ff;
         pfms_pkg::ACT_GAIN:  accel_sel = accel_gain_ff;
         pfms_pkg::ACT_FAST:  accel_sel = accel_fast_ff;
         default:             accel_sel = accel_keep_ff;
      endcase
   end

   always_comb begin
      if (path_points_ff == '0) begin
         n_c = CW'(1);
      end else if (32'(path_points_ff) > PATH_DEPTH) begin
         n_c = CW'(PATH_DEPTH);
      end else begin
         n_c = CW'(path_points_ff);
      end
   end

   assign mid_c     = lo_ff + (cnt_ff >> 1);
   assign lo_c      = (lo_ff >= n_ff) ? n_ff - CW'(1) : lo_ff;
   assign lo_m1     = lo_ff - CW'(1);
   assign prod_sh   = prod_ff >>> FRAC_BITS;
   assign v_sh      = $signed(PW'(v_ff) << FRAC_BITS);
   assign div_trial = {div_rem_ff, div_quo_ff[DW-1]};
   assign den_c     = 33'(right_ff.station) - 33'(left_ff.station);
   assign num_c     = 33'(sn_ff) - 33'(left_ff.station);
   assign den_abs   = den_c[32] ? 33'(-den_c) : 33'(den_c);
   assign num_abs   = num_c[32] ? 33'(-num_c) : 33'(num_c);
   assign quo_x     = {1'b0, div_quo_ff};

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      a_in          = a_ff;
      s_in          = s_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      ph_in         = ph_ff;
      dt_in         = dt_ff;
      v_in          = v_ff;
      t2_in         = t2_ff;
      spd_in        = spd_ff;
      acc_in        = acc_ff;
      sn_in         = sn_ff;
      w_in          = w_ff;
      ox_in         = ox_ff;
      oy_in         = oy_ff;
      lo_in         = lo_ff;
      cnt_in        = cnt_ff;
      mid_in        = mid_ff;
      n_in          = n_ff;
      right_in      = right_ff;
      left_in       = left_ff;
      mul_a_in      = mul_a_ff;
      mul_b_in      = mul_b_ff;
      div_rem_in    = div_rem_ff;
      div_den_in    = div_den_ff;
      div_quo_in    = div_quo_ff;
      div_cnt_in    = div_cnt_ff;
      div_neg_in    = div_neg_ff;
      rd_addr       = '0;
      rsp_valid_in  = 1'b0;
      rsp_st_in     = rsp_st_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_h_in      = rsp_h_ff;
      rsp_spd_in    = rsp_spd_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_interp_in = rsp_interp_ff;
      unique case (state_ff)
         pfms_pkg::ST_IDLE: begin
            if (start && req_op == pfms_pkg::OP_STEP) begin
               a_in     = accel_sel;
               dt_in    = time_step_ff;
               v_in     = req_speed;
               s_in     = req_station;
               px_in    = req_pos_x;
               py_in    = req_pos_y;
               ph_in    = req_heading;
               mul_a_in = $signed({2'b00, time_step_ff});
               mul_b_in = -33'(accel_sel);
               ret_in   = pfms_pkg::ST_STOP;
               state_in = pfms_pkg::ST_MUL;
            end
         end
         pfms_pkg::ST_MUL: begin
            state_in = ret_ff;
         end
         pfms_pkg::ST_DIV: begin
            if (div_trial >= {1'b0, div_den_ff}) begin
               div_rem_in = 33'(div_trial - {1'b0, div_den_ff});
               div_quo_in = {div_quo_ff[DW-2:0], 1'b1};
            end else begin
               div_rem_in = div_trial[32:0];
               div_quo_in = {div_quo_ff[DW-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff - DCW'(1);
            if (div_cnt_ff == '0) begin
               state_in = ret_ff;
            end
         end
         pfms_pkg::ST_STOP: begin
            if (a_ff[31] && v_sh <= prod_ff) begin
               div_quo_in = DW'(v_ff) << FRAC_BITS;
               div_den_in = 33'(-33'(a_ff));
               div_rem_in = '0;
               div_cnt_in = DCW'(DW - 1);
               ret_in     = pfms_pkg::ST_DTQ;
               state_in   = pfms_pkg::ST_DIV;
            end else begin
               mul_a_in = $signed({2'b00, dt_ff});
               mul_b_in = $signed({2'b00, dt_ff});
               ret_in   = pfms_pkg::ST_T2;
               state_in = pfms_pkg::ST_MUL;
            end
         end
         pfms_pkg::ST_DTQ: begin
            dt_in    = div_quo_ff[30:0];
            mul_a_in = $signed({2'b00, div_quo_ff[30:0]});
            mul_b_in = $signed({2'b00, div_quo_ff[30:0]});
            ret_in   = pfms_pkg::ST_T2;
            state_in = pfms_pkg::ST_MUL;
         end
         pfms_pkg::ST_T2: begin
            t2_in    = pfms_pkg::sat_u31(prod_sh);
            mul_a_in = $signed({2'b00, v_ff});
            mul_b_in = $signed({2'b00, dt_ff});
            ret_in   = pfms_pkg::ST_P1;
            state_in = pfms_pkg::ST_MUL;
         end
         pfms_pkg::ST_P1: begin
            acc_in   = PW'(s_ff) + prod_sh;
            mul_a_in = 33'(a_ff);
            mul_b_in = $signed({2'b00, t2_ff});
            ret_in   = pfms_pkg::ST_P2;
            state_in = pfms_pkg::ST_MUL;
         end
         pfms_pkg::ST_P2: begin
            sn_in    = pfms_pkg::sat_s32(acc_ff + (prod_ff >>> (FRAC_BITS + 1)));
            mul_a_in = 33'(a_ff);
            mul_b_in = $signed({2'b00, dt_ff});
            ret_in   = pfms_pkg::ST_SPD;
            state_in = pfms_pkg::ST_MUL;
         end
         pfms_pkg::ST_SPD: begin
            spd_in   = pfms_pkg::sat_u31($signed(PW'(v_ff)) + prod_sh);
            lo_in    = '0;
            cnt_in   = n_c;
            n_in     = n_c;
            state_in = pfms_pkg::ST_SRCH;
         end
         pfms_pkg::ST_SRCH: begin
            rd_addr = mid_c[AW-1:0];
            mid_in  = mid_c;
            if (cnt_ff == '0) begin
               state_in = pfms_pkg::ST_CLAMP;
            end else begin
               state_in = pfms_pkg::ST_SCMP;
            end
         end
         pfms_pkg::ST_SCMP: begin
            if (rd_ff.station < sn_ff) begin
               lo_in  = mid_ff + CW'(1);
               cnt_in = cnt_ff - (cnt_ff >> 1) - CW'(1);
            end else begin
               cnt_in = cnt_ff >> 1;
            end
            state_in = pfms_pkg::ST_SRCH;
         end
         pfms_pkg::ST_CLAMP: begin
            lo_in   = lo_c;
            rd_addr = lo_c[AW-1:0];
            if (lo_c == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_st_in     = sn_ff;
               rsp_x_in      = px_ff;
               rsp_y_in      = py_ff;
               rsp_h_in      = ph_ff;
               rsp_spd_in    = v_ff;
               rsp_idx_in    = '0;
               rsp_interp_in = 1'b0;
               state_in      = pfms_pkg::ST_IDLE;
            end else begin
               state_in = pfms_pkg::ST_RR;
            end
         end
         pfms_pkg::ST_RR: begin
            right_in = rd_ff;
            rd_addr  = lo_m1[AW-1:0];
            state_in = pfms_pkg::ST_RL;
         end
         pfms_pkg::ST_RL: begin
            left_in  = rd_ff;
            state_in = pfms_pkg::ST_WDIV;
         end
         pfms_pkg::ST_WDIV: begin
            if (den_c == '0) begin
               w_in     = '0;
               state_in = pfms_pkg::ST_LX;
            end else begin
               div_quo_in = DW'(num_abs) << FRAC_BITS;
               div_den_in = den_abs;
               div_rem_in = '0;
               div_neg_in = num_c[32] ^ den_c[32];
               div_cnt_in = DCW'(DW - 1);
               ret_in     = pfms_pkg::ST_WQ;
               state_in   = pfms_pkg::ST_DIV;
            end
         end
         pfms_pkg::ST_WQ: begin
            if (!div_neg_ff) begin
               w_in = (quo_x > (DW + 1)'(32'h7fff_ffff)) ? 32'sh7fff_ffff
                      : div_quo_ff[31:0];
            end else begin
               w_in = (quo_x > (DW + 1)'(32'h8000_0000)) ? 32'sh8000_0000
                      : 32'(-div_quo_ff[31:0]);
            end
            state_in = pfms_pkg::ST_LX;
         end
         pfms_pkg::ST_LX: begin
            mul_a_in = 33'(w_ff);
            mul_b_in = 33'(right_ff.x) - 33'(left_ff.x);
            ret_in   = pfms_pkg::ST_LXR;
            state_in = pfms_pkg::ST_MUL;
         end
         pfms_pkg::ST_LXR: begin
            ox_in    = pfms_pkg::sat_s32(PW'(left_ff.x) + prod_sh);
            mul_a_in = 33'(w_ff);
            mul_b_in = 33'(right_ff.y) - 33'(left_ff.y);
            ret_in   = pfms_pkg::ST_LYR;
            state_in = pfms_pkg::ST_MUL;
         end
         pfms_pkg::ST_LYR: begin
            oy_in    = pfms_pkg::sat_s32(PW'(left_ff.y) + prod_sh);
            mul_a_in = 33'(w_ff);
            mul_b_in = 33'(right_ff.heading) - 33'(left_ff.heading);
            ret_in   = pfms_pkg::ST_LHR;
            state_in = pfms_pkg::ST_MUL;
         end
         pfms_pkg::ST_LHR: begin
            rsp_valid_in  = 1'b1;
            rsp_st_in     = sn_ff;
            rsp_x_in      = ox_ff;
            rsp_y_in      = oy_ff;
            rsp_h_in      = pfms_pkg::sat_s32(PW'(left_ff.heading) + prod_sh);
            rsp_spd_in    = spd_ff;
            rsp_idx_in    = 10'(lo_ff);
            rsp_interp_in = 1'b1;
            state_in      = pfms_pkg::ST_IDLE;
         end
         default: begin
            state_in = pfms_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= pfms_pkg::ST_IDLE;
         ret_ff         <= pfms_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         time_step_ff   <= 31'(TS_RST);
         path_points_ff <= 11'd1;
         accel_brake_ff <= 32'(BRAKE_RST);
         accel_slow_ff  <= 32'(SLOW_RST);
         accel_keep_ff  <= '0;
         accel_gain_ff  <= 32'(GAIN_RST);
         accel_fast_ff  <= 32'(FAST_RST);
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index) inside
               pfms_pkg::CSR_TIME_STEP:   time_step_ff   <= csr_wdata[30:0];
               pfms_pkg::CSR_PATH_POINTS: path_points_ff <= csr_wdata[10:0];
               pfms_pkg::CSR_ACCEL_BRAKE: accel_brake_ff <= csr_wdata;
               pfms_pkg::CSR_ACCEL_SLOW:  accel_slow_ff  <= csr_wdata;
               pfms_pkg::CSR_ACCEL_KEEP:  accel_keep_ff  <= csr_wdata;
               pfms_pkg::CSR_ACCEL_GAIN:  accel_gain_ff  <= csr_wdata;
               pfms_pkg::CSR_ACCEL_FAST:  accel_fast_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff          <= a_in;
      s_ff          <= s_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      ph_ff         <= ph_in;
      dt_ff         <= dt_in;
      v_ff          <= v_in;
      t2_ff         <= t2_in;
      spd_ff        <= spd_in;
      acc_ff        <= acc_in;
      sn_ff         <= sn_in;
      w_ff          <= w_in;
      ox_ff         <= ox_in;
      oy_ff         <= oy_in;
      lo_ff         <= lo_in;
      cnt_ff        <= cnt_in;
      mid_ff        <= mid_in;
      n_ff          <= n_in;
      right_ff      <= right_in;
      left_ff       <= left_in;
      mul_a_ff      <= mul_a_in;
      mul_b_ff      <= mul_b_in;
      prod_ff       <= PW'(mul_a_ff * mul_b_ff);
      div_rem_ff    <= div_rem_in;
      div_den_ff    <= div_den_in;
      div_quo_ff    <= div_quo_in;
      div_cnt_ff    <= div_cnt_in;
      div_neg_ff    <= div_neg_in;
      rsp_st_ff     <= rsp_st_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_h_ff      <= rsp_h_in;
      rsp_spd_ff    <= rsp_spd_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_interp_ff <= rsp_interp_in;
   end

endmodule

/* rtl/pfms_chk.sv */
module pfms_chk (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_op,
   input logic rsp_valid
);

   // A step transaction raises busy in the next cycle.
   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_op |=> busy)
      else $error("step transaction did not raise busy");

   // A waypoint write produces no response and keeps the block free.
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_op |=> !busy && !rsp_valid)
      else $error("waypoint write made the block busy or respond");

   // The response appears exactly when a step finishes.
   a_done_rsp: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid)
      else $error("step ended without a response");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && !$past(rsp_valid))
      else $error("response outside the end of a step");

endmodule

bind path_following_motion_step_unit pfms_chk u_pfms_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_op    (req_op),
   .rsp_valid (rsp_valid)
);

/* test/path_following_motion_step_unit_tb.sv */
`timescale 1ns / 1ps
module path_following_motion_step_unit_tb;

   localparam int DEPTH = 1024;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int SETTLE_CYCLES = 200;
   localparam int RANDOM_STEPS = 560;
   localparam longint M31 = 64'h7fff_ffff;
   localparam logic signed [31:0] S_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

   typedef struct {
      logic signed [31:0] station;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] heading;
      logic [30:0]        speed;
      logic [9:0]         seg;
      logic               interp;
   } motion_type;

   typedef struct {
      logic                    is_reg;
      pfms_pkg::csr_index_type reg_idx;
      logic [31:0]             wdata;
      pfms_pkg::op_type        op;
      logic [9:0]              idx;
      logic signed [31:0]      st;
      logic signed [31:0]      px;
      logic signed [31:0]      py;
      logic signed [31:0]      ph;
      logic [30:0]             spd;
      logic [2:0]              act;
      logic                    fixed;
      motion_type              want;
   } row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic               req_op = 1'b0;
   logic [9:0]         req_point_index = '0;
   logic signed [31:0] req_station = '0;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic signed [31:0] req_heading = '0;
   logic [30:0]        req_speed = '0;
   logic [2:0]         req_action = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_next_station;
   logic signed [31:0] rsp_next_x;
   logic signed [31:0] rsp_next_y;
   logic signed [31:0] rsp_next_heading;
   logic [30:0]        rsp_next_speed;
   logic [9:0]         rsp_segment_index;
   logic               rsp_interpolated;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   path_following_motion_step_unit #(.PATH_DEPTH(DEPTH), .FRAC_BITS(16)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_point_index(req_point_index), .req_station(req_station),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_heading(req_heading),
      .req_speed(req_speed), .req_action(req_action),
      .rsp_valid(rsp_valid), .rsp_next_station(rsp_next_station),
      .rsp_next_x(rsp_next_x), .rsp_next_y(rsp_next_y),
      .rsp_next_heading(rsp_next_heading), .rsp_next_speed(rsp_next_speed),
      .rsp_segment_index(rsp_segment_index), .rsp_interpolated(rsp_interpolated),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   logic [30:0]        m_time_step;
   logic [10:0]        m_points;
   logic signed [31:0] m_accel [5];
   logic signed [31:0] station_tab [DEPTH];
   logic signed [31:0] x_tab [DEPTH];
   logic signed [31:0] y_tab [DEPTH];
   logic signed [31:0] heading_tab [DEPTH];
   bit                 written [DEPTH];

   motion_type expected_motion [$];
   row_type rows [$];
   int errors = 0;
   int cycles = 0;
   int burst_left = 0;
   int steps_done = 0;

   function automatic logic signed [31:0] sat32(input logic signed [127:0] v);
      if (v > 128'sd2147483647) begin
         return S_MAX;
      end else if (v < -128'sd2147483648) begin
         return S_MIN;
      end
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] lerp(input longint w, input logic signed [31:0] l,
                                                input logic signed [31:0] r);
      logic signed [127:0] wl, dl, p;
      wl = w;
      dl = longint'(r) - longint'(l);
      p = wl * dl;
      return sat32(l + (p >>> 16));
   endfunction

   function automatic motion_type predict_motion(input logic signed [31:0] s, px, py, ph,
                                                 input logic [30:0] spd_in,
                                                 input logic [2:0] act);
      longint a, dt, t2, v, na, num, den, w, spd;
      int n, lo, cnt, half, mid;
      motion_type r;
      v = spd_in;
      a = m_accel[act <= 3'd4 ? act : 3'd2];
      dt = m_time_step;
      if (a < 0) begin
         na = -a;
         if ((v << 16) <= dt * na) dt = (v << 16) / na;
      end
      t2 = (dt * dt) >>> 16;
      if (t2 > M31) t2 = M31;
      r.station = sat32(longint'(s) + ((v * dt) >>> 16) + ((a * t2) >>> 17));
      n = m_points;
      if (n == 0) n = 1;
      if (n > DEPTH) n = DEPTH;
      lo = 0;
      cnt = n;
      while (cnt > 0) begin
         half = cnt / 2;
         mid = lo + half;
         if (longint'(station_tab[mid]) < longint'(r.station)) begin
            lo = mid + 1;
            cnt -= half + 1;
         end else begin
            cnt = half;
         end
      end
      if (lo >= n) lo = n - 1;
      r.x = px;
      r.y = py;
      r.heading = ph;
      r.speed = spd_in;
      r.seg = lo[9:0];
      r.interp = 1'b0;
      if (lo != 0) begin
         den = longint'(station_tab[lo]) - longint'(station_tab[lo-1]);
         num = longint'(r.station) - longint'(station_tab[lo-1]);
         w = 0;
         if (den != 0) w = sat32((num * 65536) / den);
         r.x = lerp(w, x_tab[lo-1], x_tab[lo]);
         r.y = lerp(w, y_tab[lo-1], y_tab[lo]);
         r.heading = lerp(w, heading_tab[lo-1], heading_tab[lo]);
         spd = v + ((a * dt) >>> 16);
         if (spd < 0) spd = 0;
         if (spd > M31) spd = M31;
         r.speed = spd[30:0];
         r.interp = 1'b1;
      end
      return r;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      motion_type e;
      if (!reset && rsp_valid) begin
         if (expected_motion.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual station %0d",
                     $time, rsp_next_station);
            errors++;
         end else begin
            e = expected_motion.pop_front();
            check_field("next_station", e.station, rsp_next_station);
            check_field("next_x", e.x, rsp_next_x);
            check_field("next_y", e.y, rsp_next_y);
            check_field("next_heading", e.heading, rsp_next_heading);
            check_field("next_speed", e.speed, rsp_next_speed);
            check_field("segment_index", e.seg, rsp_segment_index);
            check_field("interpolated", e.interp, rsp_interpolated);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (expected_motion.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic set_reg(input pfms_pkg::csr_index_type i, input logic [31:0] d);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= i;
      csr_wdata <= d;
      @(posedge clock);
      case (i)
         pfms_pkg::CSR_TIME_STEP:   m_time_step = d[30:0];
         pfms_pkg::CSR_PATH_POINTS: m_points = d[10:0];
         default:                   m_accel[i - pfms_pkg::CSR_ACCEL_BRAKE] = d;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send(input row_type t);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            burst_left = 60;
            gap = 0;
         end else begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 9);
         end
         if (gap > 0) begin
            @(negedge clock);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      start <= 1'b1;
      req_op <= t.op;
      req_point_index <= t.idx;
      req_station <= t.st;
      req_pos_x <= t.px;
      req_pos_y <= t.py;
      req_heading <= t.ph;
      req_speed <= t.spd;
      req_action <= t.act;
      do @(posedge clock); while (busy);
      if (t.op == pfms_pkg::OP_WRITE) begin
         station_tab[t.idx] = t.st;
         x_tab[t.idx] = t.px;
         y_tab[t.idx] = t.py;
         heading_tab[t.idx] = t.ph;
         written[t.idx] = 1'b1;
      end else begin
         expected_motion.insert(expected_motion.size(), t.fixed ? t.want
                                : predict_motion(t.st, t.px, t.py, t.ph, t.spd, t.act));
         steps_done++;
      end
   endtask

   task automatic add_row(input row_type r);
      rows.insert(rows.size(), r);
   endtask

   function automatic row_type blank_row();
      row_type t;
      t.is_reg = 1'b0;
      t.reg_idx = pfms_pkg::CSR_TIME_STEP;
      t.wdata = '0;
      t.op = pfms_pkg::OP_WRITE;
      t.idx = '0;
      t.st = '0;
      t.px = '0;
      t.py = '0;
      t.ph = '0;
      t.spd = '0;
      t.act = '0;
      t.fixed = 1'b0;
      t.want = '{default: '0};
      return t;
   endfunction

   function automatic row_type mk_item(input pfms_pkg::op_type op, input logic [9:0] idx,
                                       input logic signed [31:0] st, px, py, ph,
                                       input logic [30:0] spd, input logic [2:0] act);
      row_type t;
      t = blank_row();
      t.op = op;
      t.idx = idx;
      t.st = st;
      t.px = px;
      t.py = py;
      t.ph = ph;
      t.spd = spd;
      t.act = act;
      return t;
   endfunction

   function automatic row_type mk_reg(input pfms_pkg::csr_index_type i, input logic [31:0] d);
      row_type t;
      t = blank_row();
      t.is_reg = 1'b1;
      t.reg_idx = i;
      t.wdata = d;
      return t;
   endfunction

   function automatic logic [31:0] rand_accel();
      case ($urandom_range(0, 7))
         0: return S_MIN;
         1: return S_MAX;
         2: return 0;
         3: return $urandom;
         default: return $urandom_range(0, 8 << 16) * ($urandom_range(0, 1) ? 1 : -1);
      endcase
   endfunction

   row_type t;
   int phase, path_len, prefix, n_steps, k;
   bit unsorted;
   longint st_acc, first_st, last_st, pick;
   logic [31:0] d;

   initial begin
      m_time_step = 19661;
      m_points = 1;
      m_accel = '{-262144, -131072, 0, 98304, 196608};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add_row(mk_item(pfms_pkg::OP_WRITE, 0, 0, 32'sh0064_0000, -32'sh000a_0000, 32'sh8000,
                      0, pfms_pkg::ACT_KEEP));
      t = mk_item(pfms_pkg::OP_STEP, 0, 5, 1234, -99, 7, 0, pfms_pkg::ACT_KEEP);
      t.fixed = 1'b1;
      t.want = '{station: 5, x: 1234, y: -99, heading: 7, speed: 0, seg: 0, interp: 0};
      add_row(t);
      t = mk_item(pfms_pkg::OP_STEP, 0, S_MAX, S_MIN, S_MAX, 0, '1, pfms_pkg::ACT_FAST);
      t.fixed = 1'b1;
      t.want = '{station: S_MAX, x: S_MIN, y: S_MAX, heading: 0, speed: '1, seg: 0, interp: 0};
      add_row(t);
      t = mk_item(pfms_pkg::OP_STEP, 0, S_MIN, 0, 0, S_MIN, 0, pfms_pkg::ACT_BRAKE);
      t.fixed = 1'b1;
      t.want = '{station: S_MIN, x: 0, y: 0, heading: S_MIN, speed: 0, seg: 0, interp: 0};
      add_row(t);
      add_row(mk_item(pfms_pkg::OP_STEP, 0, 0, 11, 22, 33, 31'(3 << 16), 3'd7));
      add_row(mk_item(pfms_pkg::OP_WRITE, 1, 10 << 16, 32'sh00c8_0000, S_MAX, S_MIN, 0, 0));
      add_row(mk_item(pfms_pkg::OP_WRITE, 2, 30 << 16, S_MIN, 0, S_MAX, 0, 0));
      add_row(mk_item(pfms_pkg::OP_WRITE, 3, 30 << 16, S_MAX, S_MIN, 32'sh1_0000, 0, 0));
      add_row(mk_reg(pfms_pkg::CSR_PATH_POINTS, 4));
      add_row(mk_item(pfms_pkg::OP_STEP, 0, 5 << 16, 1, 2, 3, 31'(1 << 16),
                      pfms_pkg::ACT_KEEP));
      add_row(mk_item(pfms_pkg::OP_STEP, 0, 10 << 16, 1, 2, 3, 0, pfms_pkg::ACT_KEEP));
      add_row(mk_item(pfms_pkg::OP_STEP, 0, 20 << 16, 1, 2, 3, 31'(2 << 16),
                      pfms_pkg::ACT_GAIN));
      add_row(mk_item(pfms_pkg::OP_STEP, 0, 100 << 16, 1, 2, 3, 31'(1 << 16),
                      pfms_pkg::ACT_SLOW));
      add_row(mk_item(pfms_pkg::OP_STEP, 0, -(50 << 16), 4, 5, 6, 0, pfms_pkg::ACT_KEEP));
      add_row(mk_item(pfms_pkg::OP_STEP, 0, 0, 4, 5, 6, 31'(1 << 15), pfms_pkg::ACT_BRAKE));
      add_row(mk_reg(pfms_pkg::CSR_ACCEL_BRAKE, S_MIN));
      add_row(mk_item(pfms_pkg::OP_STEP, 0, 28 << 16, 0, 0, 0, '1, pfms_pkg::ACT_BRAKE));
      add_row(mk_reg(pfms_pkg::CSR_TIME_STEP, 32'(M31)));
      add_row(mk_item(pfms_pkg::OP_STEP, 0, 0, 0, 0, 0, '1, pfms_pkg::ACT_FAST));
      add_row(mk_item(pfms_pkg::OP_STEP, 0, 2 << 16, 7, 8, 9, 31'(1 << 16), 3'd5));
      add_row(mk_reg(pfms_pkg::CSR_PATH_POINTS, 0));
      add_row(mk_item(pfms_pkg::OP_STEP, 0, 1 << 16, 7, 8, 9, 31'(1 << 16),
                      pfms_pkg::ACT_GAIN));
      add_row(mk_item(pfms_pkg::OP_STEP, 0, 1 << 16, 7, 8, 9, 31'(1 << 16), 3'd6));

      foreach (rows[i]) begin
         if (rows[i].is_reg) begin
            wait_idle();
            set_reg(rows[i].reg_idx, rows[i].wdata);
         end else begin
            send(rows[i]);
         end
      end

      steps_done = 0;
      for (phase = 0; steps_done < RANDOM_STEPS; phase++) begin
         wait_idle();
         case ($urandom_range(0, 5))
            0: d = 1;
            1: d = 32'(M31);
            2: d = $urandom;
            default: d = $urandom_range(1, 2 << 16);
         endcase
         d[31] = 1'($urandom_range(0, 1));
         set_reg(pfms_pkg::CSR_TIME_STEP, d);
         set_reg(pfms_pkg::CSR_ACCEL_BRAKE, rand_accel());
         set_reg(pfms_pkg::CSR_ACCEL_SLOW, rand_accel());
         set_reg(pfms_pkg::CSR_ACCEL_KEEP, rand_accel());
         set_reg(pfms_pkg::CSR_ACCEL_GAIN, rand_accel());
         set_reg(pfms_pkg::CSR_ACCEL_FAST, rand_accel());

         if (phase == 2) begin
            path_len = DEPTH;
         end else if ($urandom_range(0, 5) == 0) begin
            path_len = $urandom_range(17, 64);
         end else begin
            path_len = $urandom_range(1, 16);
         end
         unsorted = ($urandom_range(0, 9) == 0);
         st_acc = $signed($urandom) >>> 2;
         first_st = st_acc;
         last_st = st_acc;
         for (k = 0; k < path_len; k++) begin
            t = mk_item(pfms_pkg::OP_WRITE, 10'(k), unsorted ? 32'($urandom) : 32'(st_acc),
                        32'($urandom), 32'($urandom), 32'($urandom), 31'($urandom),
                        3'($urandom));
            send(t);
            last_st = st_acc;
            st_acc += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4 << 16);
         end
         prefix = 0;
         while (prefix < DEPTH && written[prefix]) prefix++;

         wait_idle();
         case ($urandom_range(0, 7))
            0: d = 0;
            1: d = $urandom_range(1, prefix);
            2: d = (prefix == DEPTH) ? 2047 : prefix;
            default: d = path_len;
         endcase
         if (phase == 2) d = ($urandom_range(0, 1)) ? 2047 : DEPTH;
         set_reg(pfms_pkg::CSR_PATH_POINTS, d);

         n_steps = $urandom_range(20, 60);
         for (k = 0; k < n_steps; k++) begin
            if ($urandom_range(0, 11) == 0) begin
               t = mk_item(pfms_pkg::OP_WRITE, 10'($urandom), 32'($urandom), 32'($urandom),
                           32'($urandom), 32'($urandom), 31'($urandom), 3'($urandom));
            end else begin
               if (unsorted || $urandom_range(0, 9) == 0) begin
                  pick = $signed($urandom);
               end else begin
                  pick = first_st - (8 << 16)
                         + $urandom_range(0, 32'(last_st - first_st + (16 << 16)));
                  if (pick > S_MAX) pick = S_MAX;
                  if (pick < S_MIN) pick = S_MIN;
               end
               t = mk_item(pfms_pkg::OP_STEP, 10'($urandom), 32'(pick), 32'($urandom),
                           32'($urandom), 32'($urandom),
                           ($urandom_range(0, 7) == 0) ? 31'($urandom)
                                                        : 31'($urandom_range(0, 20 << 16)),
                           ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                        : 3'($urandom_range(0, 4)));
            end
            send(t);
         end
      end

      wait_idle();
      if (errors == 0 && expected_motion.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
